[rtl/core/sorted_priority_queue_top_defines.svh]
// Assertion macros used by the queue port checker.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, inactive during reset
`define SPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// next-cycle implication, inactive during reset
`define SPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

[rtl/core/spq_pkg.sv]
// Types and codes shared by the sorted priority queue modules.
package spq_pkg;

    localparam int PRIO_W = 16;
    localparam int DATA_W = 32;
    localparam int FILL_W = 7;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } t_entry;

    // per-cell control broadcast from the top level
    typedef struct packed {
        logic ins;   // insert request taken this cycle
        logic rem;   // remove request taken this cycle
        logic occ;   // cell holds a live entry
        logic tail;  // first free cell
    } t_cell_ctl;

endpackage

[rtl/core/spq_cell.sv]
// One slot of the sorted queue: compares against the new entry and shifts.
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_prev,
    input  logic      i_prev_shift,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output logic      o_shift
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_gt;

    // the insert point and every live entry behind it move back one slot
    assign w_gt    = i_ctl.occ && (r_entry.prio > i_new.prio);
    assign o_shift = w_gt || i_ctl.tail;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && o_shift) begin
            n_entry = i_prev_shift ? i_prev : i_new;
        end else if (i_ctl.rem) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[rtl/core/sorted_priority_queue_top.sv]
// Sorted priority queue built as a chain of shifting cells.
//
// Input channel (i_in_valid / o_in_ready): each request is an insert
// (i_action = 0, with i_item_priority and i_item_data) or a remove of the
// head entry (i_action = 1). Lower priority numbers leave first; equal
// priorities leave in arrival order.
// Output channel (o_out_valid / i_out_ready): one result per request with
// o_status, the removed entry (zero unless removed) and o_fill_level.
// Latency: the result is valid the cycle after the request is taken.
// Throughput: one request per cycle. Every cell compares its priority with
// the new one and shifts in the same cycle, so one step of the cell row
// finishes a request; the output register frees o_in_ready whenever it is
// empty or being read in the same cycle.
// Receiver stall: the result holds in the output register and o_in_ready
// drops until it is taken; no request is lost.
// Reset (i_rst_n low, synchronous): the queue becomes empty and no result is
// pending. Entry storage is not cleared; only live slots are ever read.
// Insert into a full queue returns ST_FULL and changes nothing; remove from an
// empty queue returns ST_EMPTY.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [PRIO_W-1:0] i_item_priority,
    input  logic [DATA_W-1:0] i_item_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [PRIO_W-1:0] o_out_priority,
    output logic [DATA_W-1:0] o_out_data,
    output logic [FILL_W-1:0] o_fill_level
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [PRIO_W-1:0] r_out_prio;
    logic [DATA_W-1:0] r_out_data;
    logic [FILL_W-1:0] r_fill;

    logic   w_take;
    logic   w_full;
    logic   w_empty;
    logic   w_ins;
    logic   w_rem;
    t_entry w_new;
    t_entry w_entry [DEPTH];
    logic   w_shift [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_ins      = w_take && !i_action && !w_full;
    assign w_rem      = w_take && i_action && !w_empty;
    assign w_new      = '{prio: i_item_priority, data: i_item_data};

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_cell_ctl w_ctl;
            t_entry    w_prev;
            logic      w_prev_shift;
            t_entry    w_next;

            assign w_ctl.ins  = w_ins;
            assign w_ctl.rem  = w_rem;
            assign w_ctl.occ  = (CW'(gi) < r_count);
            assign w_ctl.tail = (CW'(gi) == r_count);

            if (gi == 0) begin : g_head
                assign w_prev       = '0;
                assign w_prev_shift = 1'b0;
            end else begin : g_body
                assign w_prev       = w_entry[gi-1];
                assign w_prev_shift = w_shift[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_next = w_entry[gi];
            end else begin : g_mid
                assign w_next = w_entry[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_new        (w_new),
                .i_prev       (w_prev),
                .i_prev_shift (w_prev_shift),
                .i_next       (w_next),
                .o_entry      (w_entry[gi]),
                .o_shift      (w_shift[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_rem) begin
            n_count = r_count - CW'(1);
        end
        if (i_action) begin
            n_status = w_empty ? ST_EMPTY : ST_REMOVED;
        end else begin
            n_status = w_full ? ST_FULL : ST_INSERTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status   <= n_status;
            r_out_prio <= w_rem ? w_entry[0].prio : '0;
            r_out_data <= w_rem ? w_entry[0].data : '0;
            r_fill     <= FILL_W'(n_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_out_prio;
    assign o_out_data     = r_out_data;
    assign o_fill_level   = r_fill;

endmodule

[rtl/core/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to its top level.
`include "sorted_priority_queue_top_defines.svh"

module spq_port_checker
    import spq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        o_status,
    input logic [PRIO_W-1:0] o_out_priority,
    input logic [DATA_W-1:0] o_out_data,
    input logic [FILL_W-1:0] o_fill_level
);

    `SPQ_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_out_data) && $stable(o_fill_level))
    `SPQ_ASSERT_IMP(a_ready_free, !o_out_valid, o_in_ready)
    `SPQ_ASSERT_IMP(a_zero_payload, o_out_valid && (o_status != ST_REMOVED), (o_out_priority == '0) && (o_out_data == '0))
    `SPQ_ASSERT_IMP(a_empty_fill, o_out_valid && (o_status == ST_EMPTY), o_fill_level == '0)

endmodule

bind sorted_priority_queue_top spq_port_checker u_spq_checker (.*);
